// ===== hw/rtl/bdsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsi_pkg
// Shared widths and constants for the 2x2 box downsampler with inversion.
// ----------------------------------------------------------------------------
package bdsi_pkg;

  // Default largest row width, in input pixels.
  localparam int unsigned MaxRowWidthDef = 4096;

  // Configuration register width and reset value.
  localparam int unsigned RowWidthW = 13;
  localparam logic [RowWidthW-1:0] RowWidthReset = 13'd4096;

  // Pixel, horizontal pair-sum and four-pixel sum widths.
  localparam int unsigned PixW  = 8;
  localparam int unsigned PairW = PixW + 1;
  localparam int unsigned QuadW = PixW + 2;

  // Inversion mask applied to the averaged pixel.
  localparam logic [PixW-1:0] InvMask = 8'hFF;

endpackage

// ===== hw/rtl/bdsi_line_mem.sv =====
// ----------------------------------------------------------------------------
// bdsi_line_mem
// Single-port line store for horizontal pair sums, registered read.
// ----------------------------------------------------------------------------
module bdsi_line_mem #(
  parameter int unsigned Depth = bdsi_pkg::MaxRowWidthDef / 2,
  parameter int unsigned AddrW = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [bdsi_pkg::PairW-1:0] wdata_i,
  output logic [bdsi_pkg::PairW-1:0] rdata_o
);

  logic [bdsi_pkg::PairW-1:0] mem [Depth];
  logic [bdsi_pkg::PairW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    // Hold the read word until the next read so a stalled consumer keeps it.
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/box_downsample_2x2_invert.sv =====
// ----------------------------------------------------------------------------
// box_downsample_2x2_invert
// 2x2 box-filter downsampler for one 8-bit plane, output inverted.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one pixel per transaction
//   in row-major order; frame_start_i on the first pixel of a plane returns
//   the column and row parity to zero before the pixel is taken.
//   Output channel (out_valid_o/out_ready_i) carries one pixel per 2x2
//   block: 255 xor (sum of four >> 2), with row_end_o on the last pixel of
//   an output row. A trailing odd column and an odd last row give nothing.
//   Config channel (cfg_valid_i/cfg_ready_o) writes row_width_i; it is
//   always ready and should only be used while the block is idle.
// Timing:
//   One input pixel per cycle sustained while the output accepts results.
//   The odd-column, odd-row pixel that completes a result loads the
//   line-store read word and the middle stage; the output register follows.
// Reset:
//   Position and parity clear, row width returns to 4096. The line store
//   is not cleared; every entry is written on an even row before use.
// Stall:
//   With the output stalled the block still takes one more result into
//   its middle stage, then drops in_ready_o until the output drains.
// ----------------------------------------------------------------------------
module box_downsample_2x2_invert #(
  parameter int unsigned MaxRowWidth = bdsi_pkg::MaxRowWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdsi_pkg::RowWidthW-1:0] row_width_i,
  // input pixels
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bdsi_pkg::PixW-1:0]      pixel_in_i,
  input  logic                           frame_start_i,
  // output pixels
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bdsi_pkg::PixW-1:0]      pixel_out_o,
  output logic                           row_end_o
);

  // Column index width, effective width width, compare width.
  localparam int unsigned XW  = $clog2(MaxRowWidth);
  localparam int unsigned WW  = $clog2(MaxRowWidth + 1);
  localparam int unsigned CW  = (WW > bdsi_pkg::RowWidthW) ? WW : bdsi_pkg::RowWidthW;
  localparam int unsigned LineDepth = MaxRowWidth / 2;
  localparam int unsigned AW  = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [bdsi_pkg::RowWidthW-1:0] row_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= bdsi_pkg::RowWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_width_q <= row_width_i;
    end
  end

  // Clamp width: zero acts as one, anything above the maximum as the maximum.
  logic [CW-1:0] rw_ext;
  logic [WW-1:0] w_eff;

  assign rw_ext = CW'(row_width_q);

  always_comb begin
    priority if (rw_ext == '0) begin
      w_eff = WW'(1);
    end else if (rw_ext > CW'(MaxRowWidth)) begin
      w_eff = WW'(MaxRowWidth);
    end else begin
      w_eff = rw_ext[WW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_adv, in_acc;

  // Output register can take a word when empty or draining this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Stage 0: position tracking, pair sum, line-store access
  // --------------------------------------------------------------------------
  logic [XW-1:0]             col_q, col_d;
  logic                      odd_row_q, odd_row_d;
  logic [bdsi_pkg::PixW-1:0] left_q;

  logic [XW-1:0]              x;
  logic                       odd_row_cur;
  logic [WW-1:0]              x_inc;
  logic                       last_col;
  logic                       row_end_cur;
  logic [bdsi_pkg::PairW-1:0] pair;
  logic [XW-1:0]              idx_full;
  logic [XW-1:0]              idx_clamp;
  logic [AW-1:0]              mem_addr;
  logic                       mem_we, mem_re;
  logic                       emit;

  // Frame start restarts position before this pixel is placed.
  assign x           = frame_start_i ? '0 : col_q;
  assign odd_row_cur = frame_start_i ? 1'b0 : odd_row_q;
  assign x_inc       = WW'(x) + WW'(1);
  assign last_col    = (x_inc >= w_eff);
  assign row_end_cur = (x_inc == (w_eff & ~WW'(1)));

  assign pair = bdsi_pkg::PairW'(left_q) + bdsi_pkg::PairW'(pixel_in_i);

  assign idx_full  = x >> 1;
  assign idx_clamp = (idx_full >= XW'(LineDepth)) ? XW'(LineDepth - 1) : idx_full;
  assign mem_addr  = idx_clamp[AW-1:0];

  // Odd column: even row stores the pair, odd row fetches the pair above.
  assign mem_we = in_acc && x[0] && !odd_row_cur;
  assign mem_re = in_acc && x[0] && odd_row_cur;
  assign emit   = mem_re;

  always_comb begin
    col_d     = col_q;
    odd_row_d = odd_row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d     = '0;
        odd_row_d = !odd_row_cur;
      end else begin
        col_d     = x_inc[XW-1:0];
        odd_row_d = odd_row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      odd_row_q <= 1'b0;
      left_q    <= '0;
    end else begin
      col_q     <= col_d;
      odd_row_q <= odd_row_d;
      // Keep the even-column pixel as the left half of the next pair.
      if (in_acc && !x[0]) begin
        left_q <= pixel_in_i;
      end
    end
  end

  logic [bdsi_pkg::PairW-1:0] line_rdata;

  bdsi_line_mem #(
    .Depth (LineDepth),
    .AddrW (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (pair),
    .rdata_o (line_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: wait for the line-store word, hold while the output stalls
  // --------------------------------------------------------------------------
  logic [bdsi_pkg::PairW-1:0] s1_pair_q;
  logic                       s1_row_end_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = emit;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_pair_q    <= pair;
      s1_row_end_q <= row_end_cur;
    end
  end

  logic [bdsi_pkg::QuadW-1:0] quad_sum;

  assign quad_sum = bdsi_pkg::QuadW'(line_rdata) + bdsi_pkg::QuadW'(s1_pair_q);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [bdsi_pkg::PixW-1:0] pixel_out_q;
  logic                      row_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_out_q <= bdsi_pkg::InvMask ^ quad_sum[bdsi_pkg::QuadW-1:2];
      row_end_q   <= s1_row_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign row_end_o   = row_end_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // An accepted result-producing pixel lands in the middle stage.
  a_emit_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> s1_valid_q)
    else $error("result pixel did not reach the middle stage");

  // A stalled middle stage keeps its pair and the fetched line word.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=>
      (s1_valid_q && $stable(s1_pair_q) && $stable(line_rdata)))
    else $error("middle stage changed while stalled");

  // A word leaving the middle stage is shown on the output next cycle.
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("middle stage advanced without filling the output");

  // The single line-store port is never asked to read and write at once.
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line store read and write in the same cycle");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box downsampler with inversion. A
// scoreboard class predicts each output pixel from the accepted input
// pixels and the row width in force, and checks every output transaction
// in order. Plain tasks drive the pixel and configuration channels.
// ----------------------------------------------------------------------------

class downsample_scoreboard;

  localparam int unsigned MaxW = bdsi_pkg::MaxRowWidthDef;

  typedef struct packed {
    logic [bdsi_pkg::PixW-1:0] pixel;
    logic                      row_end;
  } pixel_result_t;

  logic [bdsi_pkg::RowWidthW-1:0] row_width = bdsi_pkg::RowWidthReset;
  logic [bdsi_pkg::PixW-1:0]      left_pix  = '0;
  logic [11:0]                    column    = '0;
  logic                           odd_row   = 1'b0;
  logic [bdsi_pkg::PairW-1:0]     pair_line [MaxW/2];

  pixel_result_t expected_pixels[$];
  int unsigned   mismatches = 0;

  function void set_width(logic [bdsi_pkg::RowWidthW-1:0] w);
    row_width = w;
  endfunction

  // Zero acts as one, anything past the store acts as the largest width.
  function logic [bdsi_pkg::RowWidthW-1:0] eff_width();
    if (row_width == '0) return bdsi_pkg::RowWidthW'(1);
    if (row_width > MaxW) return MaxW[bdsi_pkg::RowWidthW-1:0];
    return row_width;
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction

  // Advance the predicted state by one accepted input pixel.
  function void take_pixel(logic [bdsi_pkg::PixW-1:0] pix, logic fs);
    logic [bdsi_pkg::RowWidthW-1:0] w;
    logic [bdsi_pkg::RowWidthW-1:0] x;
    logic [bdsi_pkg::PairW-1:0]     pair;
    logic [bdsi_pkg::QuadW-1:0]     quad;
    pixel_result_t                  r;
    w = eff_width();
    if (fs) begin
      column  = '0;
      odd_row = 1'b0;
    end
    x = {1'b0, column};
    if (!x[0]) begin
      left_pix = pix;
    end else begin
      pair = {1'b0, left_pix} + {1'b0, pix};
      if (!odd_row) begin
        pair_line[x[11:1]] = pair;
      end else begin
        quad      = {1'b0, pair_line[x[11:1]]} + {1'b0, pair};
        r.pixel   = bdsi_pkg::InvMask ^ quad[bdsi_pkg::QuadW-1:2];
        r.row_end = ((x + 1'b1) == {w[bdsi_pkg::RowWidthW-1:1], 1'b0});
        expected_pixels.push_back(r);
      end
    end
    if ((x + 1'b1) >= w) begin
      column  = '0;
      odd_row = ~odd_row;
    end else begin
      column = x[11:0] + 1'b1;
    end
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Compare one output transaction with the oldest prediction.
  function void check_pixel(logic [bdsi_pkg::PixW-1:0] pix, logic re);
    pixel_result_t e;
    if (expected_pixels.size() == 0) begin
      note_mismatch($sformatf("output pixel %0d row_end %0b with none expected", pix, re));
      return;
    end
    e = expected_pixels.pop_front();
    if (pix !== e.pixel || re !== e.row_end) begin
      note_mismatch($sformatf("pixel exp %0d got %0d, row_end exp %0b got %0b",
                              e.pixel, pix, e.row_end, re));
    end
  endfunction

endclass

module testbench;

  // Random part length and receiver hold-off, in items and cycles.
  localparam int unsigned RandItems = 1660;
  localparam int unsigned HoldCycles = 400;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [bdsi_pkg::RowWidthW-1:0] row_width_i   = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_ready_o;
  logic [bdsi_pkg::PixW-1:0]      pixel_in_i    = '0;
  logic                           frame_start_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i   = 1'b0;
  logic [bdsi_pkg::PixW-1:0]      pixel_out_o;
  logic                           row_end_o;

  // Idle controls shared between the stimulus and the receiver.
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  bit          hold_start = 1'b0;
  logic        rx_hold    = 1'b0;
  int unsigned rand_items = 0;

  downsample_scoreboard sb = new;

  box_downsample_2x2_invert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .row_width_i   (row_width_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .row_end_o     (row_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one pixel and hold it until the input transaction completes.
  // Called right after a rising edge; valid is only dropped when a gap
  // is drawn, so back-to-back items keep it high.
  task automatic send_pixel(input logic [bdsi_pkg::PixW-1:0] pix, input logic fs);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(8, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_pixel(pix, fs);
  endtask

  // Send a run of random pixels; a noisy run drops in stray frame starts.
  task automatic send_run(input int unsigned count, input bit fs_first, input bit noisy);
    logic fs;
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0 && fs_first) || (noisy && $urandom_range(99, 0) == 0);
      send_pixel(8'($urandom()), fs);
      rand_items++;
    end
  endtask

  // Stop offering, wait for every predicted pixel, then let the pipeline
  // settle on items that give no output before touching the register.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [bdsi_pkg::RowWidthW-1:0] w);
    cfg_valid_i <= 1'b1;
    row_width_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_width(w);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: draw a stall per output pixel, honor the long hold-off, and
  // check each output transaction at the edge where it completes.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(8, 0) : 0;
      if (gap > 0 || rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      sb.check_pixel(pixel_out_o, row_end_o);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering,
  // so the block fills up and stalls its input.
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned w;
    int unsigned pick;
    int unsigned old_eff;
    int unsigned eff;
    int unsigned rows;
    int unsigned tail;
    int unsigned len;
    int unsigned nframes;
    int unsigned mode;
    int unsigned seg;
    bit          fresh;

    // Hold reset, then release it once.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a partial row at the reset width gives nothing.
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    drain();

    // Narrowest useful width: all-ones and all-zeros blocks.
    write_width(13'd2);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    drain();

    // Zero width acts as one: every pixel ends a row, no output.
    write_width(13'd0);
    send_pixel(8'd10, 1'b1);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b0);
    drain();

    // Odd width: the trailing column is dropped.
    write_width(13'd3);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd2, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd4, 1'b0);
    send_pixel(8'd5, 1'b0);
    send_pixel(8'd6, 1'b0);
    drain();

    // Width narrowed mid-row: the row ends after the next pixel.
    write_width(13'd6);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd201, 1'b0);
    send_pixel(8'd202, 1'b0);
    drain();
    write_width(13'd2);
    send_pixel(8'd203, 1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd50, 1'b0);
    drain();

    // Width above the maximum: a short run of the first row at the
    // clamped width.
    write_width(13'h1FFF);
    send_run(64, 1'b1, 1'b0);
    drain();

    // Random part: segments of frames at random widths, mostly small.
    rand_items = 0;
    seg = 0;
    while (rand_items < RandItems) begin
      old_eff = sb.eff_width();
      if (seg == 0) begin
        w = 8;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 5) w = $urandom_range(1, 0);
        else if (pick < 60) w = $urandom_range(16, 2);
        else if (pick < 88) w = $urandom_range(64, 17);
        else w = $urandom_range(200, 65);
      end
      write_width(13'(w));
      eff = sb.eff_width();
      // Continue the old frame only when the width did not grow, so the
      // line store is never read ahead of its write.
      fresh = (seg == 0) || (eff > old_eff) || ($urandom_range(1, 0) == 1);

      if (seg == 0) begin
        tx_idle    = 1'b0;
        rx_idle    = 1'b1;
        hold_start = 1'b1;
        nframes    = 1;
      end else begin
        mode    = $urandom_range(3, 0);
        tx_idle = mode[0];
        rx_idle = mode[1];
        nframes = $urandom_range(3, 1);
      end

      for (int unsigned f = 0; f < nframes; f++) begin
        if (seg == 0) rows = 20;
        else if (eff > 64) rows = $urandom_range(2, 1);
        else rows = $urandom_range(6, 1);
        tail = ($urandom_range(2, 0) == 0) ? $urandom_range(eff - 1, 0) : 0;
        // Stop the random part close to its planned length.
        len = rows * eff + tail;
        if (len > RandItems - rand_items) len = RandItems - rand_items;
        send_run(len, fresh || (f > 0), 1'b1);
      end

      // Pause the sender until every predicted pixel has come out.
      drain();
      seg++;
    end

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
